### rtl/core/fdseg_pkg.sv
// Shared constants and control types of the segment FIR decimator.
`default_nettype none
package fdseg_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_TAPS_DEF       = 64;
  localparam int MAX_DECIMATION_DEF = 64;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_BITS_DEF      = 18;

  // Fixed field widths
  localparam int REG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int COEF_IDX_W  = 6;
  localparam int PEND_W      = 7;
  localparam int RES_CNT_W   = 7;
  localparam int MAX_RESULTS = 64;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_EDGES = 2'd2;

  // Input request kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic shift;  // advance the chain by one cell
    logic load;   // take the new sample instead of the neighbor
  } cell_ctrl_t;

  typedef struct packed {
    logic clr;    // clear the accumulator
    logic vld;    // tap term is valid this cycle
  } mac_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/fdseg_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module fdseg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/fdseg_cell.sv
// One history cell of the sample chain.
`default_nettype none
module fdseg_cell #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire fdseg_pkg::cell_ctrl_t         ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] new_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] nb_sample,
  output logic signed      [SAMPLE_BITS-1:0] q
);
  import fdseg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] smp_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      smp_r <= ctrl.load ? new_sample : nb_sample;
    end
  end

  assign q = smp_r;

endmodule
`default_nettype wire

### rtl/core/fdseg_mac.sv
// Shared multiply-accumulate with rounding and saturation.
`default_nettype none
module fdseg_mac #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18,
  parameter int MAX_TAPS    = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fdseg_pkg::mac_ctrl_t          ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_in,
  input  wire logic signed [COEF_BITS-1:0]   coef_in,
  output logic signed      [SAMPLE_BITS-1:0] result
);
  import fdseg_pkg::*;

  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int NAT_W = PW + $clog2(MAX_TAPS) + 1;
  localparam int ACC_W = (NAT_W > 64) ? NAT_W : 64;
  localparam int FR    = COEF_BITS - 1;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(1) << 62;
  localparam logic signed [ACC_W-1:0] ACC_LO = -(ACC_W'(1) << 62);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FR - 1);
  localparam logic signed [ACC_W-1:0] OUT_HI = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_LO = -(ACC_W'(1) << (SAMPLE_BITS - 1));

  logic signed [SAMPLE_BITS-1:0] s1_smp_r;
  logic                          s1_vld_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_sum;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       shf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctrl.vld;
    end
    s1_smp_r <= smp_in;
    prod_r   <= s1_vld_r ? PW'(coef_in * s1_smp_r) : '0;
    acc_r    <= acc_nxt;
  end

  always_comb begin
    acc_sum = acc_r + ACC_W'(prod_r);
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (acc_sum > ACC_HI) begin
      acc_nxt = ACC_HI;
    end else if (acc_sum < ACC_LO) begin
      acc_nxt = ACC_LO;
    end else begin
      acc_nxt = acc_sum;
    end
  end

  // round half up, then clip to the sample range
  always_comb begin
    rnd = acc_r + HALF;
    shf = rnd >>> FR;
    if (shf > OUT_HI) begin
      result = OUT_HI[SAMPLE_BITS-1:0];
    end else if (shf < OUT_LO) begin
      result = OUT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = shf[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/fir_decimator_segment_core.sv
// Top level of the segment FIR decimator: sample chain, coefficient RAM, MAC, control.
// A coefficient load or a sample is taken in S_IDLE; once N samples are held, each complete
//   window is run through the MAC (S_MAC, S_ROUND) and its result is sent from the queue.
// The single MAC takes one tap per cycle.
// A short segment is echoed from the chain, pausing while the output stalls.
// Reset (synchronous, rst_n low): D=1, N=1, zero-pad mode, segment state and queue empty;
//   history and coefficients stay undefined until written.
`default_nettype none
module fir_decimator_segment_core #(
  parameter int MAX_TAPS       = fdseg_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIMATION = fdseg_pkg::MAX_DECIMATION_DEF,
  parameter int SAMPLE_BITS    = fdseg_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS      = fdseg_pkg::COEF_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [fdseg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [fdseg_pkg::REG_W-1:0]            cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_kind,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  wire logic                                   in_seg_end,
  input  wire logic [fdseg_pkg::COEF_IDX_W-1:0]       in_coef_index,
  input  wire logic signed [COEF_BITS-1:0]            in_coef_value,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_sample,
  output logic                                        out_last
);
  import fdseg_pkg::*;

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int N_W    = $clog2(MAX_TAPS + 1);
  localparam int D_W    = $clog2(MAX_DECIMATION + 1);
  localparam int CNT_W  = $clog2(MAX_TAPS + 2);
  localparam int NS_W   = $clog2(MAX_TAPS + MAX_DECIMATION) + 6;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [CNT_W-1:0] LAST_TAP = CNT_W'(MAX_TAPS - 1);
  localparam logic [CNT_W-1:0] PASS_END = CNT_W'(MAX_TAPS + 1);
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOP  = 8'b0000_0010,
    S_MAC   = 8'b0000_0100,
    S_ROUND = 8'b0000_1000,
    S_POPS  = 8'b0001_0000,
    S_FINAL = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_ECHO  = 8'b1000_0000
  } state_t;

  // Control and configuration registers
  state_t                    state_r, state_nxt;
  logic [REG_W-1:0]          dfac_r, ntap_r;
  logic                      trim_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [D_W-1:0]            phase_r, phase_nxt;
  logic [PEND_W-1:0]         pend_r, pend_nxt;
  logic signed [NS_W-1:0]    ns_r, ns_nxt;
  logic [RES_CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]          e_r, e_nxt;
  logic                      drain_r, drain_nxt;
  logic [FIFO_AW-1:0]        head_r, head_nxt;
  logic [FIFO_AW:0]          fcnt_r, fcnt_nxt;
  logic                      out_vld_r, out_vld_nxt;

  // Payload registers
  logic signed [SAMPLE_BITS-1:0] held_r [FIFO_DEPTH];
  logic signed [SAMPLE_BITS-1:0] out_smp_r;
  logic                          out_last_r;

  // Combinational helpers
  logic [N_W-1:0]                eff_n;
  logic [D_W-1:0]                eff_d;
  logic signed [NS_W-1:0]        neg_n;
  logic signed [NS_W-1:0]        ns_base;
  logic [CNT_W-1:0]              cnt_inc;
  logic [D_W-1:0]                phase_inc;
  logic                          slot_free;
  logic [CNT_W-1:0]              tap_o;
  logic signed [NS_W:0]          m_s;
  logic                          tap_ok;
  logic                          pop_ok;
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] emit_smp;
  logic                          emit_last;
  logic                          do_pop;
  logic                          do_push;
  logic                          ram_we;
  cell_ctrl_t                    cctl;
  mac_ctrl_t                     mctl;
  logic signed [SAMPLE_BITS-1:0] cell_q [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic signed [SAMPLE_BITS-1:0] mac_res;

  // Clamp the configured factor and tap count into their usable ranges
  always_comb begin
    if (dfac_r == '0) begin
      eff_d = D_W'(1);
    end else if (32'(dfac_r) > MAX_DECIMATION) begin
      eff_d = D_W'(MAX_DECIMATION);
    end else begin
      eff_d = D_W'(dfac_r);
    end
    if (ntap_r == '0) begin
      eff_n = N_W'(1);
    end else if (32'(ntap_r) > MAX_TAPS) begin
      eff_n = N_W'(MAX_TAPS);
    end else begin
      eff_n = N_W'(ntap_r);
    end
  end

  assign neg_n     = -NS_W'($signed({1'b0, eff_n}));
  assign ns_base   = (cnt_r == '0) ?
                     (trim_r ? '0 : NS_W'(1) - NS_W'($signed({1'b0, eff_n >> 1}))) : ns_r;
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign phase_inc = phase_r + D_W'(1);
  assign slot_free = !out_vld_r || !out_stall;

  // The chain tail holds the sample at offset MAX_TAPS-1-e after e rotations
  assign tap_o  = LAST_TAP - e_r;
  // Coefficient index that pairs with this offset in the current window
  assign m_s    = -(NS_W + 1)'(1) - (NS_W + 1)'(ns_r) - (NS_W + 1)'($signed({1'b0, tap_o}));
  assign tap_ok = (tap_o < cnt_r) && !m_s[NS_W] &&
                  (m_s < (NS_W + 1)'($signed({1'b0, eff_n})));
  assign pop_ok = (pend_r >= PEND_W'(2)) && (fcnt_r != '0) &&
                  (32'(k_r) < MAX_RESULTS);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    ns_nxt    = ns_r;
    k_nxt     = k_r;
    e_nxt     = e_r;
    drain_nxt = drain_r;
    head_nxt  = head_r;
    fcnt_nxt  = fcnt_r;
    emit      = 1'b0;
    emit_smp  = held_r[head_r];
    emit_last = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    ram_we    = 1'b0;
    cctl      = '0;
    mctl      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_COEF) begin
            // drop loads beyond the table
            ram_we = (32'(in_coef_index) < MAX_TAPS);
          end else begin
            cctl.shift = 1'b1;
            cctl.load  = 1'b1;
            cnt_nxt    = cnt_inc;
            ns_nxt     = ns_base - NS_W'(1);
            k_nxt      = '0;
            if (!trim_r || (cnt_inc > CNT_W'(eff_n))) begin
              if (phase_inc >= eff_d) begin
                phase_nxt = '0;
                if (pend_r != PEND_MAX) begin
                  pend_nxt = pend_r + PEND_W'(1);
                end
              end else begin
                phase_nxt = phase_inc;
              end
            end
            if (in_seg_end) begin
              if (cnt_inc < CNT_W'(eff_n)) begin
                e_nxt     = '0;
                state_nxt = S_ECHO;
              end else begin
                drain_nxt = 1'b1;
                state_nxt = S_DRAIN;
              end
            end else if (cnt_inc >= CNT_W'(eff_n)) begin
              drain_nxt = 1'b0;
              state_nxt = S_LOOP;
            end
          end
        end
      end

      S_LOOP: begin
        // compute another window while it is complete and the queue has room
        if ((ns_r <= neg_n) && (fcnt_r != (FIFO_AW + 1)'(FIFO_DEPTH))) begin
          mctl.clr  = 1'b1;
          e_nxt     = '0;
          state_nxt = S_MAC;
        end else begin
          state_nxt = S_FINAL;
        end
      end

      S_MAC: begin
        if (e_r < CNT_W'(MAX_TAPS)) begin
          cctl.shift = 1'b1;
          mctl.vld   = tap_ok;
        end
        e_nxt = e_r + CNT_W'(1);
        if (e_r == PASS_END) begin
          state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        do_push   = 1'b1;
        fcnt_nxt  = fcnt_r + (FIFO_AW + 1)'(1);
        ns_nxt    = ns_r + NS_W'($signed({1'b0, eff_d}));
        state_nxt = drain_r ? S_DRAIN : S_POPS;
      end

      S_POPS, S_FINAL: begin
        // hold back the last known result until the segment ends
        if (pop_ok) begin
          if (slot_free) begin
            emit   = 1'b1;
            do_pop = 1'b1;
          end
        end else begin
          state_nxt = (state_r == S_POPS) ? S_LOOP : S_IDLE;
        end
      end

      S_DRAIN: begin
        if ((pend_r != '0) && (32'(k_r) < MAX_RESULTS)) begin
          if (fcnt_r == '0) begin
            mctl.clr  = 1'b1;
            e_nxt     = '0;
            state_nxt = S_MAC;
          end else if (slot_free) begin
            emit      = 1'b1;
            emit_last = (pend_r == PEND_W'(1));
            do_pop    = 1'b1;
          end
        end else begin
          cnt_nxt   = '0;
          phase_nxt = '0;
          pend_nxt  = '0;
          ns_nxt    = '0;
          head_nxt  = '0;
          fcnt_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_ECHO: begin
        // short segment: pass the held samples through, oldest first
        if ((tap_o >= cnt_r) || slot_free) begin
          cctl.shift = 1'b1;
          e_nxt      = e_r + CNT_W'(1);
          if (tap_o < cnt_r) begin
            emit      = 1'b1;
            emit_smp  = cell_q[MAX_TAPS-1];
            emit_last = (tap_o == '0);
          end
          if (e_r == LAST_TAP) begin
            cnt_nxt   = '0;
            phase_nxt = '0;
            pend_nxt  = '0;
            ns_nxt    = '0;
            head_nxt  = '0;
            fcnt_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_pop) begin
      head_nxt = head_r + FIFO_AW'(1);
      fcnt_nxt = fcnt_r - (FIFO_AW + 1)'(1);
      pend_nxt = pend_r - PEND_W'(1);
      k_nxt    = k_r + RES_CNT_W'(1);
    end

    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dfac_r    <= REG_W'(1);
      ntap_r    <= REG_W'(1);
      trim_r    <= 1'b0;
      cnt_r     <= '0;
      phase_r   <= '0;
      pend_r    <= '0;
      ns_r      <= '0;
      k_r       <= '0;
      e_r       <= '0;
      drain_r   <= 1'b0;
      head_r    <= '0;
      fcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      ns_r      <= ns_nxt;
      k_r       <= k_nxt;
      e_r       <= e_nxt;
      drain_r   <= drain_nxt;
      head_r    <= head_nxt;
      fcnt_r    <= fcnt_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECIMATION: dfac_r <= cfg_wdata;
          CFG_TAP_COUNT:  ntap_r <= cfg_wdata;
          CFG_TRIM_EDGES: trim_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result queue and output register
  always_ff @(posedge clk) begin
    if (do_push) begin
      held_r[head_r + fcnt_r[FIFO_AW-1:0]] <= mac_res;
    end
    if (emit) begin
      out_smp_r  <= emit_smp;
      out_last_r <= emit_last;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_sample = out_smp_r;
  assign out_last   = out_last_r;

  // Sample history: a ring of cells, cell 0 holds the newest sample
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    cell_ctrl_t cc;
    assign cc.shift = cctl.shift;
    assign cc.load  = (i == 0) ? cctl.load : 1'b0;
    fdseg_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cc),
      .new_sample(in_sample),
      .nb_sample (cell_q[(i + MAX_TAPS - 1) % MAX_TAPS]),
      .q         (cell_q[i])
    );
  end

  fdseg_ram #(
    .WIDTH(COEF_BITS),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_coef_index)),
    .wdata(in_coef_value),
    .raddr(m_s[AW-1:0]),
    .rdata(coef_rd)
  );

  fdseg_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .MAX_TAPS   (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mctl),
    .smp_in (cell_q[MAX_TAPS-1]),
    .coef_in(coef_rd),
    .result (mac_res)
  );

endmodule
`default_nettype wire
